FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Widths, codes, reset values and shared types of the envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int DUR_W      = 24;
    localparam int LEVEL_W    = 16;
    localparam int NUM_W      = DUR_W + LEVEL_W;
    localparam int QUO_W      = LEVEL_W;
    localparam int STEP_W     = $clog2(QUO_W);
    localparam int CMP_W      = (TIME_WIDTH > DUR_W + 1) ? TIME_WIDTH : DUR_W + 1;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = DUR_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd4;

    localparam logic [DUR_W-1:0]   RST_ATTACK  = 24'd4800;
    localparam logic [DUR_W-1:0]   RST_DECAY   = 24'd2400;
    localparam logic [DUR_W-1:0]   RST_RELEASE = 24'd9600;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN = 16'd26214;
    localparam logic [LEVEL_W-1:0] RST_PEAK    = 16'd32768;

    localparam logic [LEVEL_W-1:0] AMP_ONE   = 16'd32768;
    localparam logic [LEVEL_W-1:0] AMP_FLOOR = 16'd3;

    typedef struct packed {
        logic [DUR_W-1:0]   attack;
        logic [DUR_W-1:0]   decay;
        logic [DUR_W-1:0]   release_len;
        logic [LEVEL_W-1:0] sustain;
        logic [LEVEL_W-1:0] peak;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_CLASSIFY,
        ST_MULT,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_item;
        logic calc_elapsed;
        logic classify;
        logic multiply;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hdl/adsr_if.sv
// ----------------------------------------------------------------------------
// ADSR channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_in_if;
    logic                          valid;
    logic                          ready;
    logic [adsr_pkg::OP_W-1:0]       operation;
    logic [adsr_pkg::TIME_WIDTH-1:0] time_now;

    modport source (output valid, output operation, output time_now, input ready);
    modport sink   (input valid, input operation, input time_now, output ready);
endinterface

interface adsr_out_if;
    logic                         valid;
    logic                         ready;
    logic [adsr_pkg::LEVEL_W-1:0] amplitude;

    modport source (output valid, output amplitude, input ready);
    modport sink   (input valid, input amplitude, output ready);
endinterface

interface adsr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [adsr_pkg::CFG_IDX_W-1:0]  index;
    logic [adsr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/adsr_cfg.sv
// ----------------------------------------------------------------------------
// ADSR configuration registers
// Holds the envelope durations and levels, written over the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_cfg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    adsr_cfg_if.sink       i_cfg,
    output adsr_pkg::t_cfg o_cfg
);

    adsr_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack      <= adsr_pkg::RST_ATTACK;
            r_cfg.decay       <= adsr_pkg::RST_DECAY;
            r_cfg.release_len <= adsr_pkg::RST_RELEASE;
            r_cfg.sustain     <= adsr_pkg::RST_SUSTAIN;
            r_cfg.peak        <= adsr_pkg::RST_PEAK;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                adsr_pkg::REG_ATTACK:  r_cfg.attack      <= i_cfg.data;
                adsr_pkg::REG_DECAY:   r_cfg.decay       <= i_cfg.data;
                adsr_pkg::REG_RELEASE: r_cfg.release_len <= i_cfg.data;
                adsr_pkg::REG_SUSTAIN: r_cfg.sustain <= i_cfg.data[adsr_pkg::LEVEL_W-1:0];
                adsr_pkg::REG_PEAK:    r_cfg.peak    <= i_cfg.data[adsr_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/adsr_ctrl.sv
// ----------------------------------------------------------------------------
// ADSR controller
// Sequences one item through elapsed time, operand select, multiply, divide and finish.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  adsr_pkg::t_status i_status,
    output adsr_pkg::t_cmd    o_cmd
);

    adsr_pkg::t_state r_state, n_state;
    logic [adsr_pkg::STEP_W-1:0] r_step, n_step;
    logic div_last;

    assign div_last = (r_step == adsr_pkg::STEP_W'(adsr_pkg::QUO_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adsr_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            adsr_pkg::ST_IDLE:     if (i_in_valid) n_state = adsr_pkg::ST_DIFF;
            adsr_pkg::ST_DIFF:     n_state = adsr_pkg::ST_CLASSIFY;
            adsr_pkg::ST_CLASSIFY: n_state = adsr_pkg::ST_MULT;
            adsr_pkg::ST_MULT:     n_state = adsr_pkg::ST_DIVIDE;
            adsr_pkg::ST_DIVIDE:   if (div_last) n_state = adsr_pkg::ST_FINISH;
            adsr_pkg::ST_FINISH:   if (i_status.out_free) n_state = adsr_pkg::ST_IDLE;
            default:               n_state = adsr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_step     = r_step;
        unique case (r_state)
            adsr_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            adsr_pkg::ST_DIFF:     o_cmd.calc_elapsed = 1'b1;
            adsr_pkg::ST_CLASSIFY: o_cmd.classify     = 1'b1;
            adsr_pkg::ST_MULT: begin
                o_cmd.multiply = 1'b1;
                n_step         = '0;
            end
            adsr_pkg::ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + adsr_pkg::STEP_W'(1);
            end
            adsr_pkg::ST_FINISH:   o_cmd.finish = i_status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/adsr_dpath.sv
// ----------------------------------------------------------------------------
// ADSR datapath
// Note state, segment select, one multiply, restoring divider, clamp, output.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  adsr_pkg::t_cfg                     i_cfg,
    input  adsr_pkg::t_cmd                     i_cmd,
    output adsr_pkg::t_status                  o_status,
    input  wire logic [adsr_pkg::OP_W-1:0]       i_operation,
    input  wire logic [adsr_pkg::TIME_WIDTH-1:0] i_time_now,
    adsr_out_if.source                         o_result
);

    localparam int DW = adsr_pkg::DUR_W;
    localparam int LW = adsr_pkg::LEVEL_W;
    localparam int CW = adsr_pkg::CMP_W;
    localparam int NW = adsr_pkg::NUM_W;
    localparam int QW = adsr_pkg::QUO_W;

    // note state
    logic                          r_held;
    logic [adsr_pkg::TIME_WIDTH-1:0] r_start, r_stop;

    // payload
    logic [adsr_pkg::TIME_WIDTH-1:0] r_now, r_elapsed;
    logic [DW-1:0] r_mul_a, r_addend, r_divisor, r_rem;
    logic [LW-1:0] r_mul_b, r_base, r_out_amp;
    logic [QW-1:0] r_quo;
    logic          r_sub, r_out_valid;

    // segment select
    logic [DW-1:0] a_dur, d_dur, rel_dur;
    logic [CW-1:0] e_ext, a_ext, ad_ext, rl_ext;
    logic [DW-1:0] n_mul_a, n_addend, n_divisor;
    logic [LW-1:0] n_mul_b, n_base;
    logic          n_sub;

    logic [NW-1:0] num;
    logic [DW:0]   rem_shift;
    logic [DW-1:0] rem_diff;
    logic          q_bit;
    logic [LW:0]   amp_sum;
    logic [LW-1:0] amp_clamped;

    always_comb begin
        a_dur   = (i_cfg.attack == '0) ? DW'(1) : i_cfg.attack;
        d_dur   = (i_cfg.decay == '0) ? DW'(1) : i_cfg.decay;
        rel_dur = (i_cfg.release_len == '0) ? DW'(1) : i_cfg.release_len;
        e_ext  = CW'(r_elapsed);
        a_ext  = CW'(a_dur);
        ad_ext = CW'(a_dur) + CW'(d_dur);
        rl_ext = CW'(rel_dur);

        // sustain / silent defaults: zero product, value carried in base
        n_mul_a   = '0;
        n_mul_b   = '0;
        n_addend  = '0;
        n_divisor = a_dur;
        n_base    = '0;
        n_sub     = 1'b0;

        if (r_held) begin
            if (e_ext <= a_ext) begin
                n_mul_a = DW'(e_ext);
                n_mul_b = i_cfg.peak;
            end else if (e_ext <= ad_ext) begin
                n_mul_a   = DW'(e_ext - a_ext);
                n_divisor = d_dur;
                n_base    = i_cfg.peak;
                if (i_cfg.sustain >= i_cfg.peak) begin
                    n_mul_b = i_cfg.sustain - i_cfg.peak;
                end else begin
                    // falling decay rounds the step up so the level floors
                    n_mul_b  = i_cfg.peak - i_cfg.sustain;
                    n_addend = d_dur - DW'(1);
                    n_sub    = 1'b1;
                end
            end else begin
                n_base = i_cfg.sustain;
            end
        end else if (e_ext < rl_ext) begin
            n_mul_a   = DW'(rl_ext - e_ext);
            n_mul_b   = i_cfg.sustain;
            n_divisor = rel_dur;
        end
    end

    assign num = NW'(r_mul_a) * NW'(r_mul_b) + NW'(r_addend);

    // quotient always fits QW bits since the multiplicand never exceeds the divisor
    assign rem_shift = {r_rem, r_quo[QW-1]};
    assign rem_diff  = rem_shift[DW-1:0] - r_divisor;
    assign q_bit     = (rem_shift >= {1'b0, r_divisor});

    always_comb begin
        if (r_sub) begin
            amp_sum = {1'b0, r_base} - {1'b0, r_quo};
        end else begin
            amp_sum = {1'b0, r_base} + {1'b0, r_quo};
        end
        if (amp_sum >= {1'b0, adsr_pkg::AMP_ONE}) begin
            amp_clamped = adsr_pkg::AMP_ONE;
        end else begin
            amp_clamped = amp_sum[LW-1:0];
        end
        if (amp_clamped <= adsr_pkg::AMP_FLOOR) begin
            amp_clamped = '0;
        end
    end

    // note state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_start     <= '0;
            r_stop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                case (i_operation)
                    adsr_pkg::OP_NOTE_ON: begin
                        r_held  <= 1'b1;
                        r_start <= i_time_now;
                    end
                    adsr_pkg::OP_NOTE_OFF: begin
                        r_held <= 1'b0;
                        r_stop <= i_time_now;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_now <= i_time_now;
        end
        if (i_cmd.calc_elapsed) begin
            r_elapsed <= r_now - (r_held ? r_start : r_stop);
        end
        if (i_cmd.classify) begin
            r_mul_a   <= n_mul_a;
            r_mul_b   <= n_mul_b;
            r_addend  <= n_addend;
            r_divisor <= n_divisor;
            r_base    <= n_base;
            r_sub     <= n_sub;
        end
        if (i_cmd.multiply) begin
            r_rem <= num[NW-1:QW];
            r_quo <= num[QW-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_diff : rem_shift[DW-1:0];
            r_quo <= {r_quo[QW-2:0], q_bit};
        end
        if (i_cmd.finish) begin
            r_out_amp <= amp_clamped;
        end
    end

    assign o_status.out_free = !r_out_valid || o_result.ready;
    assign o_result.valid     = r_out_valid;
    assign o_result.amplitude = r_out_amp;

endmodule

`default_nettype wire

FILE: hdl/adsr_envelope_generator_top.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Linear attack/decay/sustain/release envelope, one amplitude per item.
// ----------------------------------------------------------------------------
// Each accepted item (tick, note on, note off with the current sample time)
// yields one amplitude in unsigned Q1.15. The item passes through elapsed
// time, segment select, multiply, the 16-step restoring divider that forms
// the linear ramp, and clamp; a new item is taken only once the last one is
// finished, and finishing waits while the previous result is still unread.
// The result sits in an output register, so the next item is taken while it
// waits. Register writes take effect at once and are meant for idle periods.
`default_nettype none

`include "assert_macros.svh"

module adsr_envelope_generator_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    adsr_in_if.sink   i_item,
    adsr_out_if.source o_result,
    adsr_cfg_if.sink  i_cfg
);

    adsr_pkg::t_cfg    w_cfg;
    adsr_pkg::t_cmd    w_cmd;
    adsr_pkg::t_status w_status;
    logic              w_in_ready;

    assign i_item.ready = w_in_ready;

    adsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    adsr_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_operation (i_item.operation),
        .i_time_now  (i_item.time_now),
        .o_result    (o_result)
    );

    `ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, i_item.valid && w_in_ready, !w_in_ready, "block took a second item while busy")
    `ASSERT_IMPL(a_amp_max, i_clk, i_rst_n, o_result.valid, o_result.amplitude <= adsr_pkg::AMP_ONE, "amplitude above full scale")
    `ASSERT_IMPL(a_amp_floor, i_clk, i_rst_n, o_result.valid, (o_result.amplitude == '0) || (o_result.amplitude > adsr_pkg::AMP_FLOOR), "amplitude inside the floor band")
    `ASSERT_NEXT(a_result_after_finish, i_clk, i_rst_n, w_cmd.finish, o_result.valid, "finished item did not reach the output")

endmodule

`default_nettype wire
